/* rtl/adpcm_pkg.sv */
`timescale 1ns / 1ps
package adpcm_pkg;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int COUNT_W    = 25;
   localparam int SAMPLE_W   = 16;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 34;
   localparam int FRAC_BITS  = 11;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_W-1:0] MAX_SAMPLES = COUNT_W'(20000000);
   localparam logic [3:0]         PRED_MAX    = 4'd7;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1024);
   localparam logic signed [ACC_W-1:0] SAT_HIGH   = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] SAT_LOW    = -ACC_W'(32768);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF_01 = 3'd0,
      CSR_COEFF_23 = 3'd1,
      CSR_COEFF_45 = 3'd2,
      CSR_COEFF_67 = 3'd3,
      CSR_HISTORY  = 3'd4,
      CSR_COUNT    = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [3:0][CSR_DATA_W-1:0] coeff;
      logic [31:0]                history;
      logic [COUNT_W-1:0]         count;
   } cfg_type;

   // One queue entry per input word that leaves work for the back end.
   typedef struct packed {
      logic                load;
      logic                bad;
      logic [1:0]          n_samples;
      logic                send;
      logic [7:0]          data_byte;
      logic [SAMPLE_W-1:0] c1;
      logic [SAMPLE_W-1:0] c2;
      logic [3:0]          scale_exp;
   } entry_type;

endpackage

/* rtl/adpcm_if.sv */
`timescale 1ns / 1ps
interface adpcm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] encoded_byte;
   logic       stream_start;

   modport source (output valid, output encoded_byte, output stream_start, input ready);
   modport sink (input valid, input encoded_byte, input stream_start, output ready);
endinterface

interface adpcm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] pcm_sample;
   logic               item_end;
   logic               stream_end;
   logic               bad_predictor;

   modport source (output valid, output pcm_sample, output item_end, output stream_end,
                   output bad_predictor, input ready);
   modport sink (input valid, input pcm_sample, input item_end, input stream_end,
                 input bad_predictor, output ready);
endinterface

/* rtl/adpcm_csr.sv */
`timescale 1ns / 1ps
module adpcm_csr
   import adpcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_idx_type'(csr_index))
            CSR_COEFF_01: cfg_in.coeff[0] = csr_write_data;
            CSR_COEFF_23: cfg_in.coeff[1] = csr_write_data;
            CSR_COEFF_45: cfg_in.coeff[2] = csr_write_data;
            CSR_COEFF_67: cfg_in.coeff[3] = csr_write_data;
            CSR_HISTORY:  cfg_in.history  = csr_write_data[31:0];
            CSR_COUNT:    cfg_in.count    = csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coeff   <= '0;
         cfg_ff.history <= '0;
         cfg_ff.count   <= COUNT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/adpcm_front.sv */
`timescale 1ns / 1ps
module adpcm_front
   import adpcm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   adpcm_req_if.sink         req_bus,
   input  cfg_type           cfg,
   input  logic              q_full,
   output logic              push,
   output entry_type         push_entry
);

   logic [2:0]          pos_ff, pos_in;
   logic [COUNT_W-1:0]  cnt_ff, cnt_in;
   logic                halted_ff, halted_in;
   logic [SAMPLE_W-1:0] c1_ff, c1_in, c2_ff, c2_in;
   logic [3:0]          exp_ff, exp_in;

   logic               accept;
   logic               start;
   logic [2:0]         pos_eff;
   logic [COUNT_W-1:0] cnt_eff;
   logic               halt_eff;
   logic [COUNT_W-1:0] lim;
   logic [3:0]         pred;
   logic [CSR_DATA_W-1:0] coeff_reg;
   logic [31:0]        coeff_pair;
   logic               push_need;

   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && !q_full;
   assign start  = req_bus.stream_start;
   assign pred   = req_bus.encoded_byte[7:4];

   always_comb begin
      pos_eff  = start ? 3'd0 : pos_ff;
      cnt_eff  = start ? '0 : cnt_ff;
      halt_eff = start ? 1'b0 : halted_ff;
      lim      = (cfg.count > MAX_SAMPLES) ? MAX_SAMPLES : cfg.count;

      coeff_reg  = cfg.coeff[pred[2:1]];
      coeff_pair = pred[0] ? coeff_reg[63:32] : coeff_reg[31:0];

      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      halted_in = halted_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      exp_in    = exp_ff;

      push_entry.load      = start;
      push_entry.bad       = 1'b0;
      push_entry.n_samples = 2'd0;
      push_entry.send      = 1'b0;
      push_entry.data_byte = req_bus.encoded_byte;
      push_entry.c1        = c1_ff;
      push_entry.c2        = c2_ff;
      push_entry.scale_exp = exp_ff;
      push_need            = start;

      if (accept) begin
         pos_in    = pos_eff;
         cnt_in    = cnt_eff;
         halted_in = halt_eff;
         if (!halt_eff) begin
            if (pos_eff == 3'd0) begin
               pos_in = 3'd1;
               if (cnt_eff < lim) begin
                  if (pred > PRED_MAX) begin
                     halted_in      = 1'b1;
                     push_entry.bad = 1'b1;
                     push_need      = 1'b1;
                  end else begin
                     c1_in  = coeff_pair[15:0];
                     c2_in  = coeff_pair[31:16];
                     exp_in = req_bus.encoded_byte[3:0];
                  end
               end
            end else begin
               pos_in = pos_eff + 3'd1;
               if (cnt_eff < lim) begin
                  // The second nibble is dropped once the count is met.
                  push_entry.n_samples = ((cnt_eff + COUNT_W'(1)) < lim) ? 2'd2 : 2'd1;
                  cnt_in          = cnt_eff + COUNT_W'(push_entry.n_samples);
                  push_entry.send = (cnt_in == lim);
                  push_need       = 1'b1;
               end
            end
         end
      end
   end

   assign push = accept && push_need;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         cnt_ff    <= '0;
         halted_ff <= 1'b0;
         c1_ff     <= '0;
         c2_ff     <= '0;
         exp_ff    <= '0;
      end else begin
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         halted_ff <= halted_in;
         c1_ff     <= c1_in;
         c2_ff     <= c2_in;
         exp_ff    <= exp_in;
      end
   end

endmodule

/* rtl/adpcm_queue.sv */
`timescale 1ns / 1ps
module adpcm_queue
   import adpcm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   entry_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/adpcm_back.sv */
`timescale 1ns / 1ps
module adpcm_back
   import adpcm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] history,
   input  logic        head_valid,
   input  entry_type   head_entry,
   output logic        pop,
   adpcm_rsp_if.source rsp_bus
);

   typedef enum logic {PH_MUL, PH_SUM} phase_type;

   phase_type                  ph_ff, ph_in;
   logic                       idx_ff, idx_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in, older_ff, older_in;
   logic signed [PROD_W-1:0]   p1_ff, p1_in, p2_ff, p2_in;
   logic signed [ACC_W-1:0]    sc_ff, sc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] pcm_ff, pcm_in;
   logic                       iend_ff, iend_in, send_ff, send_in, bad_ff, bad_in;

   logic                       out_free;
   logic                       use_hist;
   logic signed [SAMPLE_W-1:0] prev_eff, older_eff;
   logic [3:0]                 nib;
   logic signed [ACC_W-1:0]    nib_ext;
   logic signed [ACC_W-1:0]    acc;
   logic signed [ACC_W-1:0]    shifted;
   logic signed [SAMPLE_W-1:0] sat;
   logic                       last;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign use_hist  = !idx_ff && head_entry.load;
   assign prev_eff  = use_hist ? $signed(history[15:0]) : prev_ff;
   assign older_eff = use_hist ? $signed(history[31:16]) : older_ff;
   assign nib       = idx_ff ? head_entry.data_byte[3:0] : head_entry.data_byte[7:4];
   assign nib_ext   = $signed({{(ACC_W-4){nib[3]}}, nib});
   assign last      = idx_ff || (head_entry.n_samples == 2'd1);

   // Sum of the registered terms plus a rounding half, then an arithmetic shift and saturation.
   assign acc = $signed({{(ACC_W-PROD_W){p1_ff[PROD_W-1]}}, p1_ff})
              + $signed({{(ACC_W-PROD_W){p2_ff[PROD_W-1]}}, p2_ff})
              + sc_ff + ROUND_HALF;
   assign shifted = acc >>> FRAC_BITS;

   always_comb begin
      if (shifted > SAT_HIGH) begin
         sat = SAT_HIGH[SAMPLE_W-1:0];
      end else if (shifted < SAT_LOW) begin
         sat = SAT_LOW[SAMPLE_W-1:0];
      end else begin
         sat = shifted[SAMPLE_W-1:0];
      end
   end

   always_comb begin
      ph_in        = ph_ff;
      idx_in       = idx_ff;
      prev_in      = prev_ff;
      older_in     = older_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      sc_in        = sc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      pcm_in       = pcm_ff;
      iend_in      = iend_ff;
      send_in      = send_ff;
      bad_in       = bad_ff;
      pop          = 1'b0;

      case (ph_ff)
         PH_MUL: begin
            if (head_valid) begin
               if (head_entry.bad) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     pcm_in       = '0;
                     iend_in      = 1'b1;
                     send_in      = 1'b0;
                     bad_in       = 1'b1;
                     prev_in      = prev_eff;
                     older_in     = older_eff;
                     pop          = 1'b1;
                  end
               end else if (head_entry.n_samples == 2'd0) begin
                  // A header word: only a stream start leaves work here.
                  prev_in  = prev_eff;
                  older_in = older_eff;
                  pop      = 1'b1;
               end else begin
                  p1_in    = $signed(head_entry.c1) * prev_eff;
                  p2_in    = $signed(head_entry.c2) * older_eff;
                  sc_in    = nib_ext <<< (5'(head_entry.scale_exp) + 5'(FRAC_BITS));
                  prev_in  = prev_eff;
                  older_in = older_eff;
                  ph_in    = PH_SUM;
               end
            end
         end
         PH_SUM: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               pcm_in       = sat;
               iend_in      = last;
               send_in      = last && head_entry.send;
               bad_in       = 1'b0;
               older_in     = prev_ff;
               prev_in      = sat;
               ph_in        = PH_MUL;
               idx_in       = !last;
               pop          = last;
            end
         end
         default: ph_in = PH_MUL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff        <= PH_MUL;
         idx_ff       <= 1'b0;
         prev_ff      <= '0;
         older_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ph_ff        <= ph_in;
         idx_ff       <= idx_in;
         prev_ff      <= prev_in;
         older_ff     <= older_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_ff        <= p1_in;
         p2_ff        <= p2_in;
         sc_ff        <= sc_in;
         pcm_ff       <= pcm_in;
         iend_ff      <= iend_in;
         send_ff      <= send_in;
         bad_ff       <= bad_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.pcm_sample    = pcm_ff;
   assign rsp_bus.item_end      = iend_ff;
   assign rsp_bus.stream_end    = send_ff;
   assign rsp_bus.bad_predictor = bad_ff;

endmodule

/* rtl/dsp_adpcm_decoder_unit.sv */
`timescale 1ns / 1ps
// Decoder for one channel of 4-bit ADPCM. Each word on req_bus is one encoded byte;
// stream_start marks the header byte that opens a stream and reloads the history.
// Frames are eight bytes: a header (predictor, scale exponent) and seven data bytes
// of two samples each. Each sample leaves on rsp_bus as one word, item_end marking the
// last word caused by a byte and stream_end the last sample of the programmed count.
// A header with a predictor above seven, before the count is met, gives one word with
// bad_predictor set and halts decoding until the next stream start.
// The input side takes a byte every cycle while its four-entry queue has room.
// The decode unit handles each sample in a multiply step and then a sum-and-saturate step,
// and as each sample needs the one before it, it starts no sample before the last is done;
// a header that carries a stream start takes a step of its own. A sample passes from the
// queue through the product registers to the output register.
// The output register lets the decode unit do the multiply step of the next sample while a
// word waits to be taken; a stalled receiver backs up into the queue and then drops req_bus.ready.
// Reset empties the queue and the output register and clears all state but the data registers
// of the decode unit; the registers on the csr_ port return to their defaults (sample count one).
module dsp_adpcm_decoder_unit
   import adpcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   adpcm_req_if.sink             req_bus,
   adpcm_rsp_if.source           rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type   cfg;
   logic      q_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   adpcm_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   adpcm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   adpcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   adpcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .history    (cfg.history),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

/* rtl/adpcm_checker.sv */
`timescale 1ns / 1ps
module adpcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pcm_sample,
   input logic        rsp_item_end,
   input logic        rsp_stream_end,
   input logic        rsp_bad_predictor
);

   // A word held back by the receiver stays as it is.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pcm_sample)
         && $stable(rsp_item_end) && $stable(rsp_stream_end) && $stable(rsp_bad_predictor))
      else $error("rsp word changed while stalled");

   a_bad_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_predictor |->
         rsp_pcm_sample == 16'd0 && rsp_item_end && !rsp_stream_end)
      else $error("malformed error word");

   // The last sample of a stream is always the last word of its byte.
   a_stream_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_item_end)
      else $error("stream_end without item_end");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind dsp_adpcm_decoder_unit adpcm_checker u_adpcm_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_pcm_sample    (rsp_bus.pcm_sample),
   .rsp_item_end      (rsp_bus.item_end),
   .rsp_stream_end    (rsp_bus.stream_end),
   .rsp_bad_predictor (rsp_bus.bad_predictor)
);
